/* rtl/aca_pkg.sv */
package aca_pkg;

    localparam int FRAC_BITS = 30;
    localparam int MAX_TERMS = 1023;

    localparam int ARG_W     = 32;
    localparam int ANGLE_W   = 32;
    localparam int THR_W     = 31;
    localparam int TERMS_W   = 10;
    localparam int T_W       = FRAC_BITS + 1;
    localparam int N_W       = $clog2(MAX_TERMS + 1);
    localparam int C_W       = N_W + 1;
    localparam int COEF_W    = 2 * N_W + 2;
    localparam int PROD_W    = 2 * T_W;
    localparam int DIVD_W    = T_W + COEF_W;
    localparam int CNT_W     = $clog2(T_W);
    localparam int SUM_W     = 32;

    localparam logic [T_W-1:0]     ONE_Q         = T_W'(1) << FRAC_BITS;
    localparam logic [SUM_W-1:0]   HALF_PI       = 32'h6487ED51;
    localparam logic [THR_W-1:0]   THR_RESET     = 31'd1074;
    localparam logic [ANGLE_W-1:0] ANGLE_MAX     = '1;
    localparam logic [N_W-1:0]     N_CAP         = N_W'(MAX_TERMS);
    localparam logic [COEF_W-1:0]  DEN_FIRST     = COEF_W'(6);

    typedef enum logic [8:0] {
        ST_IDLE     = 9'b000000001,
        ST_SQUARE   = 9'b000000010,
        ST_LATCH_X2 = 9'b000000100,
        ST_SCALE    = 9'b000001000,
        ST_COEF     = 9'b000010000,
        ST_DIV_LOAD = 9'b000100000,
        ST_DIV_WAIT = 9'b001000000,
        ST_ACC      = 9'b010000000,
        ST_FINISH   = 9'b100000000
    } aca_state_t;

    typedef struct packed {
        logic load_arg;
        logic do_square;
        logic latch_x2;
        logic do_scale;
        logic do_coef;
        logic div_start;
        logic acc;
        logic load_out;
    } aca_cmd_t;

    typedef struct packed {
        logic div_done;
        logic stop;
    } aca_sts_t;

endpackage

/* rtl/aca_div.sv */
module aca_div (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [aca_pkg::DIVD_W-1:0]     dividend,
    input  logic [aca_pkg::COEF_W-1:0]     divisor,
    output logic                           done,
    output logic [aca_pkg::T_W-1:0]        quotient
);

    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [aca_pkg::CNT_W-1:0]     cnt_reg, cnt_next;
    logic [aca_pkg::COEF_W-1:0]    rem_reg, rem_next;
    logic [aca_pkg::COEF_W-1:0]    den_reg, den_next;
    logic [aca_pkg::T_W-1:0]       qr_reg, qr_next;
    logic [aca_pkg::COEF_W:0]      rem_shift;
    logic [aca_pkg::COEF_W:0]      rem_diff;
    logic                          q_bit;

    // Restoring division, one quotient bit per cycle. The quotient register
    // shifts the low dividend bits out at the top and the quotient bits in.
    always_comb
    begin
        rem_shift = {rem_reg, qr_reg[aca_pkg::T_W-1]};
        rem_diff  = rem_shift - {1'b0, den_reg};
        q_bit     = (rem_shift >= {1'b0, den_reg});
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        qr_next   = qr_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = dividend[aca_pkg::DIVD_W-1:aca_pkg::T_W];
            den_next  = divisor;
            qr_next   = dividend[aca_pkg::T_W-1:0];
        end
        else if (busy_reg)
        begin
            rem_next = q_bit ? rem_diff[aca_pkg::COEF_W-1:0]
                             : rem_shift[aca_pkg::COEF_W-1:0];
            qr_next  = {qr_reg[aca_pkg::T_W-2:0], q_bit};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == aca_pkg::CNT_W'(aca_pkg::T_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        qr_reg  <= qr_next;
    end

    assign done     = done_reg;
    assign quotient = qr_reg;

endmodule

/* rtl/aca_datapath.sv */
module aca_datapath (
    input  logic                             clk,
    input  logic                             rst_n,
    input  aca_pkg::aca_cmd_t                cmd,
    output aca_pkg::aca_sts_t                sts,
    input  logic                             cfg_write,
    input  logic [aca_pkg::THR_W-1:0]        cfg_data,
    input  logic signed [aca_pkg::ARG_W-1:0] argument,
    output logic [aca_pkg::ANGLE_W-1:0]      angle,
    output logic [aca_pkg::TERMS_W-1:0]      terms_added,
    output logic                             cap_reached
);

    logic [aca_pkg::THR_W-1:0]   thr_reg;
    logic [aca_pkg::T_W-1:0]     m_reg, x2_reg, t_reg;
    logic                        neg_reg;
    logic [aca_pkg::SUM_W-1:0]   s_reg;
    logic [aca_pkg::N_W-1:0]     n_reg;
    logic [aca_pkg::C_W-1:0]     c_reg;
    logic [aca_pkg::COEF_W-1:0]  c2_reg, d_reg;
    logic [aca_pkg::PROD_W-1:0]  prod_reg, prod_next;
    logic [aca_pkg::ANGLE_W-1:0] angle_reg, angle_next;
    logic [aca_pkg::TERMS_W-1:0] terms_reg;
    logic                        cap_reg;

    logic [aca_pkg::ARG_W-1:0]   raw;
    logic [aca_pkg::ARG_W-1:0]   mag;
    logic [aca_pkg::T_W-1:0]     m_sat;
    logic [aca_pkg::T_W-1:0]     op_a, op_b;
    logic [aca_pkg::T_W-1:0]     t_scaled;
    logic [aca_pkg::T_W-1:0]     quot;
    logic                        div_done;
    logic [aca_pkg::SUM_W:0]     sum_neg;

    assign raw   = argument;
    assign mag   = raw[aca_pkg::ARG_W-1] ? (~raw + 1'b1) : raw;
    assign m_sat = (mag > aca_pkg::ARG_W'(aca_pkg::ONE_Q)) ? aca_pkg::ONE_Q
                                                          : mag[aca_pkg::T_W-1:0];

    assign t_scaled = prod_reg[aca_pkg::FRAC_BITS+aca_pkg::T_W-1:aca_pkg::FRAC_BITS];

    // One shared multiplier serves the square, the x-squared scaling and the
    // odd-square coefficient.
    always_comb
    begin
        op_a = m_reg;
        op_b = m_reg;
        if (cmd.do_scale)
        begin
            op_a = t_reg;
            op_b = x2_reg;
        end
        else if (cmd.do_coef)
        begin
            op_a = t_scaled;
            op_b = aca_pkg::T_W'(c2_reg);
        end
        prod_next = aca_pkg::PROD_W'(op_a) * aca_pkg::PROD_W'(op_b);
    end

    aca_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (prod_reg[aca_pkg::DIVD_W-1:0]),
        .divisor  (d_reg),
        .done     (div_done),
        .quotient (quot)
    );

    assign sts.div_done = div_done;
    assign sts.stop     = (quot < thr_reg) || (n_reg == aca_pkg::N_CAP);

    always_comb
    begin
        sum_neg = {1'b0, aca_pkg::HALF_PI} + {1'b0, s_reg};
        if (neg_reg)
        begin
            angle_next = sum_neg[aca_pkg::SUM_W] ? aca_pkg::ANGLE_MAX
                                                 : sum_neg[aca_pkg::ANGLE_W-1:0];
        end
        else
        begin
            angle_next = (s_reg > aca_pkg::HALF_PI) ? '0 : (aca_pkg::HALF_PI - s_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= aca_pkg::THR_RESET;
        end
        else if (cfg_write)
        begin
            thr_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.do_square || cmd.do_scale || cmd.do_coef)
        begin
            prod_reg <= prod_next;
        end
        if (cmd.load_arg)
        begin
            m_reg   <= m_sat;
            neg_reg <= raw[aca_pkg::ARG_W-1];
            t_reg   <= m_sat;
            s_reg   <= aca_pkg::SUM_W'(m_sat);
            n_reg   <= aca_pkg::N_W'(1);
            c_reg   <= aca_pkg::C_W'(1);
            c2_reg  <= aca_pkg::COEF_W'(1);
            d_reg   <= aca_pkg::DEN_FIRST;
        end
        if (cmd.latch_x2)
        begin
            x2_reg <= t_scaled;
        end
        if (cmd.acc)
        begin
            t_reg <= quot;
            s_reg <= s_reg + aca_pkg::SUM_W'(quot);
            if (!sts.stop)
            begin
                n_reg  <= n_reg + 1'b1;
                c_reg  <= c_reg + aca_pkg::C_W'(2);
                c2_reg <= c2_reg + aca_pkg::COEF_W'({c_reg, 2'b00}) + aca_pkg::COEF_W'(4);
                d_reg  <= d_reg + aca_pkg::COEF_W'({n_reg, 3'b000}) + aca_pkg::COEF_W'(6);
            end
        end
        if (cmd.load_out)
        begin
            angle_reg <= angle_next;
            terms_reg <= n_reg[aca_pkg::TERMS_W-1:0];
            cap_reg   <= (t_reg >= thr_reg);
        end
    end

    assign angle       = angle_reg;
    assign terms_added = terms_reg;
    assign cap_reached = cap_reg;

endmodule

/* rtl/aca_ctrl.sv */
module aca_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output aca_pkg::aca_cmd_t cmd,
    input  aca_pkg::aca_sts_t sts
);

    aca_pkg::aca_state_t state_reg, state_next;
    logic                out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            aca_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_arg = 1'b1;
                    state_next   = aca_pkg::ST_SQUARE;
                end
            end
            aca_pkg::ST_SQUARE:
            begin
                cmd.do_square = 1'b1;
                state_next    = aca_pkg::ST_LATCH_X2;
            end
            aca_pkg::ST_LATCH_X2:
            begin
                cmd.latch_x2 = 1'b1;
                state_next   = aca_pkg::ST_SCALE;
            end
            aca_pkg::ST_SCALE:
            begin
                cmd.do_scale = 1'b1;
                state_next   = aca_pkg::ST_COEF;
            end
            aca_pkg::ST_COEF:
            begin
                cmd.do_coef = 1'b1;
                state_next  = aca_pkg::ST_DIV_LOAD;
            end
            aca_pkg::ST_DIV_LOAD:
            begin
                cmd.div_start = 1'b1;
                state_next    = aca_pkg::ST_DIV_WAIT;
            end
            aca_pkg::ST_DIV_WAIT:
            begin
                if (sts.div_done)
                begin
                    state_next = aca_pkg::ST_ACC;
                end
            end
            aca_pkg::ST_ACC:
            begin
                cmd.acc    = 1'b1;
                state_next = sts.stop ? aca_pkg::ST_FINISH : aca_pkg::ST_SCALE;
            end
            aca_pkg::ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = aca_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = aca_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= aca_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == aca_pkg::ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

/* rtl/arccos_series_approx_unit.sv */
// Arccos of a signed Q1.30 argument, computed as pi/2 minus the arcsin Taylor series.
// The input channel (in_valid, in_ready, argument) takes one request at a time;
// in_ready is high only while the unit is idle.
// The output channel (out_valid, out_ready, angle, terms_added, cap_reached) is
// driven from an output register, so a finished result may wait there while
// the next request is already being computed.
// The configuration channel (cfg_valid, cfg_ready, term_threshold) is always ready
// and should only be written while no request is in flight.
// Each series term costs one shared multiply for the x-squared scaling, one for
// the odd-square coefficient, and a radix-2 divider that produces the 31
// quotient bits one per cycle.
// in_ready rises in the same cycle as out_valid, so the next request can be
// accepted in that same cycle at the earliest; no new request is taken before
// the last one has finished.
// Reset idles the controller, drops out_valid and sets the term threshold to 1074.
// When the receiver stalls, the result holds in the output register; a second
// finished result waits inside the unit until the first one is taken.
module arccos_series_approx_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic signed [aca_pkg::ARG_W-1:0] argument,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [aca_pkg::ANGLE_W-1:0]      angle,
    output logic [aca_pkg::TERMS_W-1:0]      terms_added,
    output logic                             cap_reached,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [aca_pkg::THR_W-1:0]        term_threshold
);

    aca_pkg::aca_cmd_t cmd;
    aca_pkg::aca_sts_t sts;

    assign cfg_ready = 1'b1;

    aca_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    aca_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .cfg_write   (cfg_valid && cfg_ready),
        .cfg_data    (term_threshold),
        .argument    (argument),
        .angle       (angle),
        .terms_added (terms_added),
        .cap_reached (cap_reached)
    );

endmodule

/* rtl/aca_checker.sv */
module aca_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             in_valid,
    input logic                             in_ready,
    input logic                             out_valid,
    input logic                             out_ready,
    input logic [aca_pkg::ANGLE_W-1:0]      angle,
    input logic [aca_pkg::TERMS_W-1:0]      terms_added,
    input logic                             cap_reached
);

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(angle) && $stable(terms_added))
    else $error("Stalled result changed or dropped.");

    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
    else $error("Unit accepted a request while busy.");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> terms_added != '0)
    else $error("Result reports no added term.");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && cap_reached |-> terms_added == aca_pkg::TERMS_W'(aca_pkg::MAX_TERMS))
    else $error("Cap flag set below the term limit.");

endmodule

bind arccos_series_approx_unit aca_checker u_aca_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .angle       (angle),
    .terms_added (terms_added),
    .cap_reached (cap_reached)
);
